// ----- hw/rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and helpers for the sorted list table: the request and
// result formats, command and status codes, and value conversions.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned ITEM_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OCC_W       = 6;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_VALUE = 3'd1,
    CMD_DEL_FIRST = 3'd2,
    CMD_DEL_LAST  = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_LIST      = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_INS_TAIL
  } fsm_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [ITEM_W-1:0] value;
  } slt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [ITEM_W-1:0] item;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } slt_res_t;

  // sign-extend the request field, then wrap to the stored width
  function automatic value_t to_value(input logic signed [ITEM_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // low bits of the sign-extended stored value
  function automatic logic [ITEM_W-1:0] to_item(input value_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ITEM_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input cnt_t c);
    return OCC_W'(c);
  endfunction

endpackage

// ----- hw/rtl/sorted_list_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_list_table_top
// Ascending sorted table of signed values held in one synchronous memory,
// with insert, delete by value, delete first, delete last, clear and list.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Clear, unused codes
// and any command refused for a full or empty table answer in the next cycle.
// Insert, delete and list walk the memory one entry per cycle with a single
// read and a single write port: insert walks down from the last entry,
// delete last reads only the last entry, the other deletes and list walk
// up from the first, and list streams one transfer per cycle. Each result
// is held on res_o for exactly one cycle under res_valid_o and must be taken
// then; the next command may be given while the final result is still shown.
module sorted_list_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  slt_pkg::slt_req_t req_i,
  output logic             res_valid_o,
  output slt_pkg::slt_res_t res_o
);

  slt_pkg::fsm_e          state_q, state_d;
  logic [slt_pkg::CMD_W-1:0] cmd_q, cmd_d;
  slt_pkg::value_t        x_q, x_d;
  slt_pkg::cnt_t          count_q, count_d;
  slt_pkg::idx_t          rd_idx_q, rd_idx_d;
  logic                   more_q, more_d;
  logic                   dv_q;
  slt_pkg::idx_t          dat_idx_q;
  logic                   found_q, found_d;
  slt_pkg::value_t        got_q, got_d;
  slt_pkg::slt_res_t      res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  slt_pkg::value_t        mem [slt_pkg::CAPACITY];
  slt_pkg::value_t        rdata_q;

  logic                   issue, fin, we, match, dat_is_last, rdata_lt;
  slt_pkg::idx_t          waddr, last_idx;
  slt_pkg::value_t        wdata, got_val;

  assign busy        = (state_q != slt_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign last_idx    = slt_pkg::idx_t'(count_q - slt_pkg::cnt_t'(1));
  assign dat_is_last = (slt_pkg::cnt_t'(dat_idx_q) == (count_q - slt_pkg::cnt_t'(1)));
  assign rdata_lt    = (rdata_q < x_q);
  assign got_val     = found_q ? got_q : rdata_q;

  always_comb begin
    unique case (cmd_q)
      slt_pkg::CMD_DEL_VALUE: match = (rdata_q == x_q);
      slt_pkg::CMD_DEL_FIRST: match = (dat_idx_q == '0);
      default:                match = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    more_d      = more_q;
    found_d     = found_q;
    got_d       = got_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    fin         = 1'b0;
    issue       = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = x_q;

    unique case (state_q)
      slt_pkg::S_IDLE: begin
        if (start) begin
          cmd_d           = req_i.command;
          x_d             = slt_pkg::to_value(req_i.value);
          found_d         = 1'b0;
          got_d           = '0;
          res_d.status    = slt_pkg::STATUS_OK;
          res_d.item      = '0;
          res_d.occupancy = slt_pkg::to_occ(count_q);
          res_d.last      = 1'b1;
          unique case (req_i.command)
            slt_pkg::CMD_INSERT: begin
              if (count_q >= slt_pkg::cnt_t'(slt_pkg::CAPACITY)) begin
                res_d.status = slt_pkg::STATUS_FULL;
                res_valid_d  = 1'b1;
              end else if (count_q == '0) begin
                we              = 1'b1;
                waddr           = '0;
                wdata           = slt_pkg::to_value(req_i.value);
                count_d         = slt_pkg::cnt_t'(1);
                res_d.occupancy = slt_pkg::to_occ(slt_pkg::cnt_t'(1));
                res_valid_d     = 1'b1;
              end else begin
                state_d  = slt_pkg::S_WALK;
                rd_idx_d = last_idx;
                more_d   = 1'b1;
              end
            end
            slt_pkg::CMD_DEL_VALUE, slt_pkg::CMD_DEL_FIRST, slt_pkg::CMD_LIST: begin
              if (count_q == '0) begin
                res_d.status = slt_pkg::STATUS_MISSING;
                res_valid_d  = 1'b1;
              end else begin
                state_d  = slt_pkg::S_WALK;
                rd_idx_d = '0;
                more_d   = 1'b1;
              end
            end
            slt_pkg::CMD_DEL_LAST: begin
              if (count_q == '0) begin
                res_d.status = slt_pkg::STATUS_MISSING;
                res_valid_d  = 1'b1;
              end else begin
                state_d  = slt_pkg::S_WALK;
                rd_idx_d = last_idx;
                more_d   = 1'b1;
              end
            end
            slt_pkg::CMD_CLEAR: begin
              count_d         = '0;
              res_d.occupancy = '0;
              res_valid_d     = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      slt_pkg::S_WALK: begin
        if (dv_q) begin
          unique case (cmd_q)
            slt_pkg::CMD_INSERT: begin
              we = 1'b1;
              waddr = dat_idx_q + slt_pkg::idx_t'(1);
              if (rdata_lt) begin
                wdata = x_q;
                fin   = 1'b1;
              end else begin
                wdata = rdata_q;
                if (dat_idx_q == '0) begin
                  state_d = slt_pkg::S_INS_TAIL;
                end
              end
              if (fin) begin
                count_d         = count_q + slt_pkg::cnt_t'(1);
                res_d.status    = slt_pkg::STATUS_OK;
                res_d.item      = '0;
                res_d.occupancy = slt_pkg::to_occ(count_q + slt_pkg::cnt_t'(1));
                res_d.last      = 1'b1;
                res_valid_d     = 1'b1;
              end
            end
            slt_pkg::CMD_DEL_VALUE, slt_pkg::CMD_DEL_FIRST, slt_pkg::CMD_DEL_LAST: begin
              if (found_q) begin
                we    = 1'b1;
                waddr = dat_idx_q - slt_pkg::idx_t'(1);
                wdata = rdata_q;
              end else if (match) begin
                found_d = 1'b1;
                got_d   = rdata_q;
              end
              if (dat_is_last) begin
                fin         = 1'b1;
                res_d.last  = 1'b1;
                res_valid_d = 1'b1;
                if (found_q || match) begin
                  count_d         = count_q - slt_pkg::cnt_t'(1);
                  res_d.status    = slt_pkg::STATUS_OK;
                  res_d.item      = slt_pkg::to_item(got_val);
                  res_d.occupancy = slt_pkg::to_occ(count_q - slt_pkg::cnt_t'(1));
                end else begin
                  res_d.status    = slt_pkg::STATUS_MISSING;
                  res_d.item      = '0;
                  res_d.occupancy = slt_pkg::to_occ(count_q);
                end
              end
            end
            slt_pkg::CMD_LIST: begin
              res_d.status    = slt_pkg::STATUS_OK;
              res_d.item      = slt_pkg::to_item(rdata_q);
              res_d.occupancy = slt_pkg::to_occ(count_q);
              res_d.last      = dat_is_last;
              res_valid_d     = 1'b1;
              fin             = dat_is_last;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end

        issue = more_q && !fin;
        if (issue) begin
          if (cmd_q == slt_pkg::CMD_INSERT) begin
            rd_idx_d = rd_idx_q - slt_pkg::idx_t'(1);
            more_d   = (rd_idx_q != '0);
          end else begin
            rd_idx_d = rd_idx_q + slt_pkg::idx_t'(1);
            more_d   = (slt_pkg::cnt_t'(rd_idx_q) != (count_q - slt_pkg::cnt_t'(1)));
          end
        end
        if (fin) begin
          more_d  = 1'b0;
          state_d = slt_pkg::S_IDLE;
        end
      end

      slt_pkg::S_INS_TAIL: begin
        we              = 1'b1;
        waddr           = '0;
        wdata           = x_q;
        count_d         = count_q + slt_pkg::cnt_t'(1);
        res_d.status    = slt_pkg::STATUS_OK;
        res_d.item      = '0;
        res_d.occupancy = slt_pkg::to_occ(count_q + slt_pkg::cnt_t'(1));
        res_d.last      = 1'b1;
        res_valid_d     = 1'b1;
        state_d         = slt_pkg::S_IDLE;
      end

      default: begin
        state_d = slt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slt_pkg::S_IDLE;
      count_q     <= '0;
      more_q      <= 1'b0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      more_q      <= more_d;
      dv_q        <= issue;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    x_q       <= x_d;
    rd_idx_q  <= rd_idx_d;
    dat_idx_q <= rd_idx_q;
    got_q     <= got_d;
    res_q     <= res_d;
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slt_pkg::cnt_t'(slt_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_final_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> state_q == slt_pkg::S_IDLE)
    else $error("final transfer while a walk is still running");

  a_partial_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> state_q == slt_pkg::S_WALK)
    else $error("non-final transfer outside a list walk");

  a_accept_reacts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_q)
    else $error("accepted command neither walking nor answered");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> slt_pkg::cnt_t'(waddr) < slt_pkg::cnt_t'(slt_pkg::CAPACITY))
    else $error("write beyond the table");

endmodule
